### rtl/chacha20_stream_cipher_top_macros.svh
// Assertion helpers for the stream cipher top level.
// Each macro expects clk and rst_n in scope.
`ifndef CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CC_ASSERT_IMP(lbl, ante, cons, msg)
`define CC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/cc20_pkg.sv
package cc20_pkg;

  // sizes
  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int WORD_W            = 32;
  localparam int NUM_WORDS         = 16;
  localparam int IDX_W             = 4;
  localparam int CFG_W             = 64;
  localparam int CFG_IDX_W         = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY01     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY23     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY45     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY67     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_NONCE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE23   = 3'd5;

  // constant words 0..3 of the cipher state (index 0 in the low slot)
  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'hFD06C16F, 32'hA3D14186, 32'hCAB5636C, 32'hA4757138
  };

  // block engine status toward the byte sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } cc20_stat_t;

endpackage

### rtl/cc20_qstep.sv
// Shared arithmetic unit: one add, then xor and rotate of the sum into a
// second word. One quarter round is four passes through here.
module cc20_qstep import cc20_pkg::*; (
  input  word_t      x,
  input  word_t      y,
  input  word_t      z,
  input  logic [1:0] step,
  output word_t      sum,
  output word_t      mix
);

  word_t mixed;

  function automatic word_t rotl_step(word_t v, logic [1:0] s);
    word_t r;
    case (s)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  assign sum   = x + y;
  assign mixed = z ^ sum;
  assign mix   = rotl_step(mixed, step);

endmodule

### rtl/cc20_core.sv
// Keystream block engine. The 16-word state sits in fixed registers; the
// quarter round always works on taps 0, 4, 8 and 12, and each row is rotated
// after every quarter round so the next column (or diagonal) lands there.
module cc20_core import cc20_pkg::*; #(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  state_t           init_w,
  input  word_t            blk_idx,
  input  logic [IDX_W-1:0] rd_idx,
  output word_t            rd_word,
  output cc20_stat_t       stat
);

  localparam int DRW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [DRW-1:0] DR_LAST = DRW'(DOUBLE_ROUNDS - 1);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_LOAD = 4'b0010,
    C_RND  = 4'b0100,
    C_FIN  = 4'b1000
  } cst_t;

  cst_t           state_r, state_nxt;
  logic [1:0]     st_r, st_nxt;
  logic [1:0]     qr_r, qr_nxt;
  logic           diag_r, diag_nxt;
  logic [DRW-1:0] dr_r, dr_nxt;
  state_t         w_r, w_nxt;
  word_t          init12_r, init12_nxt;

  word_t            ux, uy, uz, usum, umix;
  logic [IDX_W-1:0] fidx;
  state_t           tap, rot;

  assign fidx = {qr_r, st_r};

  // operand select for the shared unit
  always_comb begin
    ux = w_r[0];
    uy = w_r[4];
    uz = w_r[12];
    case (state_r)
      C_LOAD: begin
        ux = init_w[12];
        uy = blk_idx;
      end
      C_RND: begin
        if (st_r[0]) begin
          ux = w_r[8];
          uy = w_r[12];
          uz = w_r[4];
        end
      end
      C_FIN: begin
        ux = w_r[fidx];
        uy = (fidx == IDX_W'(12)) ? init12_r : init_w[fidx];
      end
      default: ;
    endcase
  end

  cc20_qstep u_qstep (
    .x    (ux),
    .y    (uy),
    .z    (uz),
    .step (st_r),
    .sum  (usum),
    .mix  (umix)
  );

  // write back the step into the taps
  always_comb begin
    tap = w_r;
    if (st_r[0]) begin
      tap[8] = usum;
      tap[4] = umix;
    end else begin
      tap[0]  = usum;
      tap[12] = umix;
    end
  end

  // row rotation after a quarter round; the last one of a half also
  // enters or leaves the diagonal arrangement
  always_comb begin
    logic [1:0] amt;
    logic [1:0] sel;
    rot = tap;
    for (int r = 0; r < 4; r++) begin
      if (qr_r == 2'd3 && !diag_r) begin
        amt = 2'(r) + 2'd1;
      end else if (qr_r == 2'd3) begin
        amt = 2'd1 - 2'(r);
      end else begin
        amt = 2'd1;
      end
      for (int i = 0; i < 4; i++) begin
        sel = 2'(i) + amt;
        rot[4*r+i] = tap[4*r + int'(sel)];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    qr_nxt     = qr_r;
    diag_nxt   = diag_r;
    dr_nxt     = dr_r;
    w_nxt      = w_r;
    init12_nxt = init12_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          state_nxt = C_LOAD;
        end
      end
      C_LOAD: begin
        w_nxt      = init_w;
        w_nxt[12]  = usum;
        init12_nxt = usum;
        st_nxt     = '0;
        qr_nxt     = '0;
        diag_nxt   = 1'b0;
        dr_nxt     = '0;
        state_nxt  = C_RND;
      end
      C_RND: begin
        st_nxt = st_r + 2'd1;
        if (st_r == 2'd3) begin
          w_nxt  = rot;
          qr_nxt = qr_r + 2'd1;
          if (qr_r == 2'd3) begin
            diag_nxt = !diag_r;
            if (diag_r) begin
              dr_nxt = dr_r + DRW'(1);
              if (dr_r == DR_LAST) begin
                dr_nxt    = '0;
                state_nxt = C_FIN;
              end
            end
          end
        end else begin
          w_nxt = tap;
        end
      end
      C_FIN: begin
        w_nxt[fidx]      = usum;
        {qr_nxt, st_nxt} = fidx + IDX_W'(1);
        if (fidx == IDX_W'(NUM_WORDS - 1)) begin
          state_nxt = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      st_r    <= '0;
      qr_r    <= '0;
      diag_r  <= 1'b0;
      dr_r    <= '0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      qr_r    <= qr_nxt;
      diag_r  <= diag_nxt;
      dr_r    <= dr_nxt;
    end
  end

  // state words, no reset
  always_ff @(posedge clk) begin
    w_r      <= w_nxt;
    init12_r <= init12_nxt;
  end

  assign rd_word   = w_r[rd_idx];
  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = (state_r == C_FIN) && (fidx == IDX_W'(NUM_WORDS - 1));

endmodule

### rtl/chacha20_stream_cipher_top.sv
// Channel | Dir | Width | Content
// in_*    | in  | 8+1   | tdata: message byte [7:0]; tlast: last byte of message
// out_*   | out | 8+1   | tdata: byte xor keystream [7:0]; tlast: copy of input tlast
// cfg_*   | in  | 3/64  | register index, write data; written when cfg_we is high
//
// Inside a 64-byte block a byte passes through accept and xor; the result is registered at the xor.
// At a block boundary: accept, load, four add/xor/rotate steps per quarter round over DOUBLE_ROUNDS
// double rounds, 16 final adds, xor; the result is registered at the xor.
// Synchronous active-low reset clears configuration, byte offset and block count.
// in_tready is high only while the sequencer is idle; a stalled output holds one result
// while the next byte may still be accepted.
`include "chacha20_stream_cipher_top_macros.svh"

module chacha20_stream_cipher_top import cc20_pkg::*; #(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_in
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] data_out
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_GEN  = 3'b010,
    T_XOR  = 3'b100
  } tst_t;

  tst_t                   state_r, state_nxt;
  logic [3:0][CFG_W-1:0]  key_r;
  logic [CFG_W-1:0]       ctr_nonce_r;
  logic [CFG_W-1:0]       nonce23_r;
  logic [5:0]             off_r;
  word_t                  blk_r;
  logic [7:0]             byte_r;
  logic                   blast_r;
  logic                   out_valid_r;
  logic [7:0]             out_data_r;
  logic                   out_last_r;

  logic       accept, commit, slot_free;
  state_t     init_w;
  word_t      ks_word;
  logic [7:0] ks_byte;
  cc20_stat_t core_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      ctr_nonce_r <= '0;
      nonce23_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KEY01:     key_r[0]    <= cfg_wdata;
        CFG_KEY23:     key_r[1]    <= cfg_wdata;
        CFG_KEY45:     key_r[2]    <= cfg_wdata;
        CFG_KEY67:     key_r[3]    <= cfg_wdata;
        CFG_CTR_NONCE: ctr_nonce_r <= cfg_wdata;
        CFG_NONCE23:   nonce23_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // initial cipher state, counter word before the block offset is added
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i]       = SIGMA[i];
      init_w[4+2*i]   = key_r[i][WORD_W-1:0];
      init_w[5+2*i]   = key_r[i][CFG_W-1:WORD_W];
    end
    init_w[12] = ctr_nonce_r[WORD_W-1:0];
    init_w[13] = ctr_nonce_r[CFG_W-1:WORD_W];
    init_w[14] = nonce23_r[WORD_W-1:0];
    init_w[15] = nonce23_r[CFG_W-1:WORD_W];
  end

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && (off_r == '0)),
    .init_w  (init_w),
    .blk_idx (blk_r),
    .rd_idx  (off_r[5:2]),
    .rd_word (ks_word),
    .stat    (core_stat)
  );

  // keystream byte, little-endian within the word
  always_comb begin
    case (off_r[1:0])
      2'd0:    ks_byte = ks_word[7:0];
      2'd1:    ks_byte = ks_word[15:8];
      2'd2:    ks_byte = ks_word[23:16];
      default: ks_byte = ks_word[31:24];
    endcase
  end

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign commit    = (state_r == T_XOR) && slot_free;

  // byte sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          state_nxt = (off_r == '0) ? T_GEN : T_XOR;
        end
      end
      T_GEN: begin
        if (core_stat.done) begin
          state_nxt = T_XOR;
        end
      end
      T_XOR: begin
        if (slot_free) begin
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      off_r       <= '0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        if (blast_r) begin
          off_r <= '0;
          blk_r <= '0;
        end else begin
          off_r <= off_r + 6'd1;
          if (off_r == 6'h3F) begin
            blk_r <= blk_r + 32'd1;
          end
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r  <= in_tdata;
      blast_r <= in_tlast;
    end
    if (commit) begin
      out_data_r <= byte_r ^ ks_byte;
      out_last_r <= blast_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  `CC_ASSERT_IMP(a_core_idle, (state_r == T_IDLE), !core_stat.busy, "core busy while idle")
  `CC_ASSERT_IMP(a_done_in_gen, core_stat.done, (state_r == T_GEN), "block done outside wait")
  `CC_ASSERT_NXT(a_last_rst, commit && blast_r, (off_r == '0) && (blk_r == '0), "restart missed")

endmodule
